@@ rtl/rc3_pkg.sv @@
// Shared types, constants and register codes of the RGB 3x3 convolution block.
// Depends on nothing; every other file of the block but rc3_stream_if refers to it by scoped names.
`timescale 1ns / 1ps

package rc3_pkg;

  // Default line length the line stores are sized for
  localparam int MaxWidthDef = 2048;
  // Tallest image the row counter covers
  localparam int MaxHeight   = 2048;
  localparam int KernelSize  = 3;
  localparam int NumTaps     = KernelSize * KernelSize;
  localparam int TapIdxW     = 4;

  localparam int PixW   = 8;
  localparam int RgbW   = 3 * PixW;
  localparam int CoefW  = 16;
  localparam int KRowW  = KernelSize * CoefW;
  localparam int DivW   = 16;
  localparam int DimW   = 12;
  localparam int PosW   = 11;
  // Signed window sum: 9 * 255 * 32768 needs 27 magnitude bits plus sign
  localparam int AccW   = 28;
  localparam int QuoW   = AccW - 1;
  localparam int ProdW  = PixW + 1 + CoefW;
  localparam int DivSteps = QuoW;
  localparam int StepW  = 5;
  localparam logic [PixW-1:0] PixMax = 8'd255;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = KRowW;

  // Configuration register codes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KROW_TOP = 3'd0,
    REG_KROW_MID = 3'd1,
    REG_KROW_BOT = 3'd2,
    REG_DIVISOR  = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } cfg_idx_e;

  // Per-pixel sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_DIVLD,
    ST_DIV,
    ST_DONE
  } state_e;

  // Control bundle from the sequencer to each channel lane
  typedef struct packed {
    logic clear;
    logic mac;
    logic div_load;
    logic div_step;
  } lane_ctl_t;

  typedef struct packed {
    logic [PixW-1:0] blue_in;
    logic [PixW-1:0] green_in;
    logic [PixW-1:0] red_in;
  } pix_in_t;

  typedef struct packed {
    logic [PixW-1:0] red_out;
    logic [PixW-1:0] green_out;
    logic [PixW-1:0] blue_out;
    logic [PosW-1:0] out_row;
    logic [PosW-1:0] out_col;
    logic            frame_last;
  } pix_out_t;

endpackage

@@ rtl/rc3_stream_if.sv @@
// Valid/ready stream channel carrying one request payload of type T.
// Depends on nothing; payload types come from rc3_pkg at the instance.
`timescale 1ns / 1ps

interface rc3_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rgb_conv3x3_div_clamp_top.sv @@
// Top level of the RGB 3x3 convolution with divide and clamp.
// Depends on rc3_pkg, rc3_stream_if, rc3_line_store and rc3_lane.
`timescale 1ns / 1ps

// Pixels enter in raster order on pix_i; one result leaves on res_o for each
// interior pixel, tagged with the window center's row and column, and border
// pixels give nothing. A pixel is taken only once the previous one is through:
// a border pixel passes the accept and the line store and window update; an
// interior one also 9 multiply-accumulate steps, one divider load, 27 divider
// steps and the hand-off of the result to the output register, which waits
// while that register holds a result not yet taken. Each of the three channel
// lanes has a 9-tap accumulate and a 27-step bit-serial divider. A finished
// result waits in its output register while the next pixel is already taken.
// The line stores need no clearing after reset. Configuration registers are
// written through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle, a
// rule for the user that the block does not enforce; writing the image width or height restarts the frame.

module rgb_conv3x3_div_clamp_top #(
  parameter int MAX_WIDTH = rc3_pkg::MaxWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rc3_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rc3_pkg::CfgDataW-1:0] cfg_data_i,
  rc3_stream_if.sink                   pix_i,
  rc3_stream_if.source                 res_o
);

  localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CmpW  = (AddrW + 1 > rc3_pkg::DimW) ? AddrW + 1 : rc3_pkg::DimW;

  // Configuration registers
  logic [rc3_pkg::KRowW-1:0] kern_q [rc3_pkg::KernelSize];
  logic [rc3_pkg::DivW-1:0]  div_q;
  logic [rc3_pkg::DimW-1:0]  width_q;
  logic [rc3_pkg::DimW-1:0]  height_q;
  rc3_pkg::cfg_idx_e         cfg_sel;

  // Position and sequencer
  logic [AddrW-1:0]          col_q, col_d;
  logic [rc3_pkg::PosW-1:0]  row_q, row_d;
  rc3_pkg::state_e           state_q, state_d;
  logic [rc3_pkg::StepW-1:0] step_q, step_d;

  // Pixel path
  logic [rc3_pkg::RgbW-1:0]  pix_q;
  logic [rc3_pkg::RgbW-1:0]  win_q [6];
  logic [rc3_pkg::RgbW-1:0]  win_d [6];
  logic [rc3_pkg::RgbW-1:0]  taps_q [rc3_pkg::NumTaps];
  logic [rc3_pkg::RgbW-1:0]  taps_d [rc3_pkg::NumTaps];
  logic [rc3_pkg::RgbW-1:0]  cur [rc3_pkg::KernelSize];
  logic [rc3_pkg::RgbW-1:0]  rd_older, rd_newer;
  logic [rc3_pkg::CoefW-1:0] coef_arr [rc3_pkg::NumTaps];
  logic [rc3_pkg::TapIdxW-1:0] tap_idx;
  logic [rc3_pkg::RgbW-1:0]  tap_sel;
  logic [rc3_pkg::CoefW-1:0] coef_sel;

  // Geometry
  logic [CmpW-1:0]           w_ext;
  logic [AddrW-1:0]          w_last;
  logic [rc3_pkg::DimW-1:0]  h_ext;
  logic [rc3_pkg::PosW-1:0]  h_last;
  logic [AddrW-1:0]          col_m1;
  logic                      emit;

  // Result tag and output register
  logic [rc3_pkg::PosW-1:0]  tag_row_q;
  logic [rc3_pkg::PosW-1:0]  tag_col_q;
  logic                      tag_last_q;
  rc3_pkg::lane_ctl_t        lane_ctl;
  logic [rc3_pkg::PixW-1:0]  lane_res [3];
  logic                      out_load;
  logic                      out_valid_q;
  rc3_pkg::pix_out_t         out_data_q;

  assign cfg_sel = rc3_pkg::cfg_idx_e'(cfg_idx_i);

  // Config register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kern_q[0] <= '0;
      kern_q[1] <= rc3_pkg::KRowW'(48'h10000);
      kern_q[2] <= '0;
      div_q     <= rc3_pkg::DivW'(1);
      width_q   <= rc3_pkg::DimW'(640);
      height_q  <= rc3_pkg::DimW'(480);
    end else if (cfg_we_i) begin
      case (cfg_sel)
        rc3_pkg::REG_KROW_TOP: kern_q[0] <= cfg_data_i;
        rc3_pkg::REG_KROW_MID: kern_q[1] <= cfg_data_i;
        rc3_pkg::REG_KROW_BOT: kern_q[2] <= cfg_data_i;
        rc3_pkg::REG_DIVISOR:  div_q     <= cfg_data_i[rc3_pkg::DivW-1:0];
        rc3_pkg::REG_WIDTH:    width_q   <= cfg_data_i[rc3_pkg::DimW-1:0];
        rc3_pkg::REG_HEIGHT:   height_q  <= cfg_data_i[rc3_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the image geometry to the supported range
  always_comb begin
    w_ext = CmpW'(width_q);
    if (w_ext < CmpW'(3)) begin
      w_ext = CmpW'(3);
    end else if (w_ext > CmpW'(MAX_WIDTH)) begin
      w_ext = CmpW'(MAX_WIDTH);
    end
    w_last = AddrW'(w_ext - 1'b1);
    h_ext = height_q;
    if (h_ext < rc3_pkg::DimW'(3)) begin
      h_ext = rc3_pkg::DimW'(3);
    end else if (h_ext > rc3_pkg::DimW'(rc3_pkg::MaxHeight)) begin
      h_ext = rc3_pkg::DimW'(rc3_pkg::MaxHeight);
    end
    h_last = rc3_pkg::PosW'(h_ext - 1'b1);
  end

  assign emit   = (row_q >= rc3_pkg::PosW'(2)) && (col_q >= AddrW'(2));
  assign col_m1 = col_q - 1'b1;

  // Advance the raster position; a geometry write restarts the frame
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i && (cfg_sel == rc3_pkg::REG_WIDTH || cfg_sel == rc3_pkg::REG_HEIGHT)) begin
      col_d = '0;
      row_d = '0;
    end else if (state_q == rc3_pkg::ST_LOAD) begin
      if (col_q >= w_last) begin
        col_d = '0;
        row_d = (row_q >= h_last) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // Line stores, addressed by the incoming pixel's column
  rc3_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_lines (
    .clk_i      (clk_i),
    .addr_i     (col_q),
    .wr_en_i    (state_q == rc3_pkg::ST_LOAD),
    .wr_data_i  (pix_q),
    .rd_older_o (rd_older),
    .rd_newer_o (rd_newer)
  );

  assign cur[0] = rd_older;
  assign cur[1] = rd_newer;
  assign cur[2] = pix_q;

  // Snapshot the 3x3 taps and shift the column window
  always_comb begin
    for (int i = 0; i < rc3_pkg::KernelSize; i++) begin
      taps_d[i*3]     = win_q[i*2];
      taps_d[i*3 + 1] = win_q[i*2 + 1];
      taps_d[i*3 + 2] = cur[i];
      win_d[i*2]      = win_q[i*2 + 1];
      win_d[i*2 + 1]  = cur[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (state_q == rc3_pkg::ST_LOAD) begin
      win_q <= win_d;
    end
  end

  // Payload captures: incoming pixel, taps and result tag
  always_ff @(posedge clk_i) begin
    if (pix_i.valid && pix_i.ready) begin
      pix_q <= {pix_i.data.blue_in, pix_i.data.green_in, pix_i.data.red_in};
    end
    if (state_q == rc3_pkg::ST_LOAD) begin
      taps_q     <= taps_d;
      tag_row_q  <= row_q - 1'b1;
      tag_col_q  <= rc3_pkg::PosW'(col_m1);
      tag_last_q <= (row_q == h_last) && (col_q == w_last);
    end
  end

  // Unpack coefficients: top row first, left coefficient in the low bits
  always_comb begin
    for (int i = 0; i < rc3_pkg::KernelSize; i++) begin
      for (int p = 0; p < rc3_pkg::KernelSize; p++) begin
        coef_arr[i*3 + p] = kern_q[i][p*rc3_pkg::CoefW +: rc3_pkg::CoefW];
      end
    end
  end

  assign tap_idx  = (state_q == rc3_pkg::ST_MAC) ? step_q[rc3_pkg::TapIdxW-1:0] : '0;
  assign tap_sel  = taps_q[tap_idx];
  assign coef_sel = coef_arr[tap_idx];

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rc3_pkg::ST_IDLE:  if (pix_i.valid) state_d = rc3_pkg::ST_LOAD;
      rc3_pkg::ST_LOAD:  state_d = emit ? rc3_pkg::ST_MAC : rc3_pkg::ST_IDLE;
      rc3_pkg::ST_MAC: begin
        if (step_q == rc3_pkg::StepW'(rc3_pkg::NumTaps - 1)) state_d = rc3_pkg::ST_DIVLD;
      end
      rc3_pkg::ST_DIVLD: state_d = rc3_pkg::ST_DIV;
      rc3_pkg::ST_DIV: begin
        if (step_q == rc3_pkg::StepW'(rc3_pkg::DivSteps - 1)) state_d = rc3_pkg::ST_DONE;
      end
      rc3_pkg::ST_DONE:  if (out_load) state_d = rc3_pkg::ST_IDLE;
      default:           state_d = rc3_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    pix_i.ready       = 1'b0;
    lane_ctl          = '0;
    out_load          = 1'b0;
    case (state_q)
      rc3_pkg::ST_IDLE:  pix_i.ready = 1'b1;
      rc3_pkg::ST_LOAD:  lane_ctl.clear = 1'b1;
      rc3_pkg::ST_MAC:   lane_ctl.mac = 1'b1;
      rc3_pkg::ST_DIVLD: lane_ctl.div_load = 1'b1;
      rc3_pkg::ST_DIV:   lane_ctl.div_step = 1'b1;
      rc3_pkg::ST_DONE:  out_load = !out_valid_q || res_o.ready;
      default: ;
    endcase
  end

  assign step_d = (state_d != state_q) ? '0 : step_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rc3_pkg::ST_IDLE;
      step_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      col_q   <= col_d;
      row_q   <= row_d;
    end
  end

  // Three channel lanes work side by side
  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    rc3_lane u_lane (
      .clk_i     (clk_i),
      .ctl_i     (lane_ctl),
      .pix_i     (tap_sel[ch*rc3_pkg::PixW +: rc3_pkg::PixW]),
      .coef_i    (coef_sel),
      .divisor_i (div_q),
      .result_o  (lane_res[ch])
    );
  end

  // Merge the lane results with the tag into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.red_out    <= lane_res[0];
      out_data_q.green_out  <= lane_res[1];
      out_data_q.blue_out   <= lane_res[2];
      out_data_q.out_row    <= tag_row_q;
      out_data_q.out_col    <= tag_col_q;
      out_data_q.frame_last <= tag_last_q;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

endmodule

@@ rtl/rc3_line_store.sv @@
// Two line stores holding the previous two image rows, one RGB pixel per entry.
// Depends on rc3_pkg for the pixel width.
`timescale 1ns / 1ps

module rc3_line_store #(
  parameter int MAX_WIDTH = rc3_pkg::MaxWidthDef,
  localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                     clk_i,
  input  logic [AddrW-1:0]         addr_i,
  input  logic                     wr_en_i,
  input  logic [rc3_pkg::RgbW-1:0] wr_data_i,
  output logic [rc3_pkg::RgbW-1:0] rd_older_o,
  output logic [rc3_pkg::RgbW-1:0] rd_newer_o
);

  logic [rc3_pkg::RgbW-1:0] older_mem [MAX_WIDTH];
  logic [rc3_pkg::RgbW-1:0] newer_mem [MAX_WIDTH];
  logic [rc3_pkg::RgbW-1:0] older_rd_q;
  logic [rc3_pkg::RgbW-1:0] newer_rd_q;

  // Read both stores every cycle; on write, age the newer entry into the older store
  always_ff @(posedge clk_i) begin
    older_rd_q <= older_mem[addr_i];
    newer_rd_q <= newer_mem[addr_i];
    if (wr_en_i) begin
      older_mem[addr_i] <= newer_rd_q;
      newer_mem[addr_i] <= wr_data_i;
    end
  end

  assign rd_older_o = older_rd_q;
  assign rd_newer_o = newer_rd_q;

endmodule

@@ rtl/rc3_lane.sv @@
// One color channel lane: 9-step multiply-accumulate, bit-serial divide, clamp.
// Depends on rc3_pkg for widths and the lane control struct.
`timescale 1ns / 1ps

module rc3_lane (
  input  logic                      clk_i,
  input  rc3_pkg::lane_ctl_t        ctl_i,
  input  logic [rc3_pkg::PixW-1:0]  pix_i,
  input  logic [rc3_pkg::CoefW-1:0] coef_i,
  input  logic [rc3_pkg::DivW-1:0]  divisor_i,
  output logic [rc3_pkg::PixW-1:0]  result_o
);

  logic signed [rc3_pkg::ProdW-1:0] prod;
  logic signed [rc3_pkg::AccW-1:0]  acc_q, acc_d;
  logic [rc3_pkg::QuoW-1:0]         quo_q, quo_d;
  logic [rc3_pkg::DivW-1:0]         rem_q, rem_d;
  logic                             neg_q, neg_d;
  logic [rc3_pkg::DivW-1:0]         div_eff;
  logic [rc3_pkg::DivW:0]           rem_sh;

  // A zero divisor behaves as one
  assign div_eff = (divisor_i == '0) ? rc3_pkg::DivW'(1) : divisor_i;
  assign prod    = $signed({1'b0, pix_i}) * $signed(coef_i);
  assign rem_sh  = {rem_q, quo_q[rc3_pkg::QuoW-1]};

  // Accumulate, then divide the bits below the sign one quotient bit per step
  always_comb begin
    acc_d = acc_q;
    quo_d = quo_q;
    rem_d = rem_q;
    neg_d = neg_q;
    if (ctl_i.clear) begin
      acc_d = '0;
    end else if (ctl_i.mac) begin
      acc_d = acc_q + rc3_pkg::AccW'(prod);
    end
    if (ctl_i.div_load) begin
      neg_d = acc_q[rc3_pkg::AccW-1];
      quo_d = acc_q[rc3_pkg::QuoW-1:0];
      rem_d = '0;
    end else if (ctl_i.div_step) begin
      if (rem_sh >= {1'b0, div_eff}) begin
        rem_d = rc3_pkg::DivW'(rem_sh - {1'b0, div_eff});
        quo_d = {quo_q[rc3_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[rc3_pkg::DivW-1:0];
        quo_d = {quo_q[rc3_pkg::QuoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  // Clamp: a negative sum truncates to zero or below, so it reads as zero
  always_comb begin
    if (neg_q) begin
      result_o = '0;
    end else if (quo_q[rc3_pkg::QuoW-1:rc3_pkg::PixW] != '0) begin
      result_o = rc3_pkg::PixMax;
    end else begin
      result_o = quo_q[rc3_pkg::PixW-1:0];
    end
  end

endmodule

@@ rtl/rc3_checker.sv @@
// Port-level checks of the RGB 3x3 convolution top level, and their bind.
// Depends on rgb_conv3x3_div_clamp_top and rc3_pkg for the row width.
`timescale 1ns / 1ps

module rc3_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [rc3_pkg::PosW-1:0] out_row_i
);

  // Hold a result request until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped before it was taken");

  // One pixel at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("pixel accepted while the previous one is still loading");

  // A result never appears the cycle after a pixel is accepted
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result appeared too soon after a pixel was accepted");

  // Results never carry row 0, the top border row
  a_interior_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_row_i != '0)
    else $error("result tagged with a border row");

endmodule

bind rgb_conv3x3_div_clamp_top rc3_checker u_rc3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pix_i.valid),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_row_i   (res_o.data.out_row)
);
